>>> src/bmrtc_pkg.sv
package bmrtc_pkg;

  localparam int RAM_BANKS_DEF = 4;
  localparam int BANK_BYTES    = 8192;
  localparam int HALT_BIT      = 38;

  localparam logic [2:0] CFG_BANKS_RST  = 3'd4;
  localparam logic [3:0] CLOCK_FIRST    = 4'h8;
  localparam logic [3:0] CLOCK_LAST     = 4'hC;
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0] LATCH_ARM      = 8'h00;
  localparam logic [7:0] LATCH_FIRE     = 8'h01;
  localparam logic [7:0] REFUSED_BYTE   = 8'hFF;
  localparam logic [6:0] ROM_BANK_RST   = 7'd1;

  localparam logic       OP_READ  = 1'b0;
  localparam logic       OP_WRITE = 1'b1;

  // Top three address bits of the external RAM and clock window.
  localparam logic [2:0] WINDOW_PAGE = 3'b101;

  // Control register group selected by address bits 14:13.
  localparam logic [1:0] CTL_RAM_ENABLE = 2'd0;
  localparam logic [1:0] CTL_ROM_BANK   = 2'd1;
  localparam logic [1:0] CTL_SELECT     = 2'd2;
  localparam logic [1:0] CTL_LATCH      = 2'd3;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_ROM     = 3'd1,
    TGT_RAM     = 3'd2,
    TGT_CLOCK   = 3'd3,
    TGT_CONTROL = 3'd4
  } target_t;

endpackage

>>> src/bmrtc_in_if.sv
interface bmrtc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] bus_address;
  logic [7:0]  write_byte;
  logic [39:0] live_clock;

  modport source (output valid, output opcode, output bus_address, output write_byte,
                  output live_clock, input ready);
  modport sink (input valid, input opcode, input bus_address, input write_byte,
                input live_clock, output ready);
endinterface

>>> src/bmrtc_out_if.sv
interface bmrtc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [20:0] rom_address;
  logic [7:0]  read_byte;
  logic        access_error;

  modport source (output valid, output target, output rom_address, output read_byte,
                  output access_error, input ready);
  modport sink (input valid, input target, input rom_address, input read_byte,
                input access_error, output ready);
endinterface

>>> src/bank_mapper_with_rtc_latch_unit.sv
// Channel   Direction  Contents
// in_ch     sink       opcode, bus_address, write_byte, live_clock
// out_ch    source     target, rom_address, read_byte, access_error
// cfg_*     write      fitted RAM bank count (3 bits), no read-back
//
// One access is taken per cycle while in_ch.ready is high; its result passes through
// the read stage, where the synchronous RAM is read, and then the output register.
// After reset the banked RAM is swept to zero, one byte a cycle, over all
// RAM_BANKS * 8192 bytes; no access is taken until the sweep ends.
// A stalled output holds the result and a second one in the read stage; further
// accesses wait only when both are full.
module bank_mapper_with_rtc_latch_unit #(
  parameter int RAM_BANKS = bmrtc_pkg::RAM_BANKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  bmrtc_in_if.sink          in_ch,
  bmrtc_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata
);

  localparam int DEPTH  = RAM_BANKS * bmrtc_pkg::BANK_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [3:0] BANKS_MAX = 4'(RAM_BANKS);

  // Control state.
  logic [2:0] bank_cnt_r;
  logic       ram_en_r,   ram_en_nxt;
  logic [6:0] rom_bank_r, rom_bank_nxt;
  logic [3:0] sel_r,      sel_nxt;
  logic [7:0] prev_r,     prev_nxt;
  logic [7:0] clk_lat_r [5];
  logic       latch_all;
  logic       latch_one;

  // Clearing sweep.
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // Banked RAM.
  logic [7:0]        ram_mem [DEPTH];
  logic [7:0]        ram_q_r;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              item_ram_we;
  logic [ADDR_W-1:0] item_addr;

  // Pipeline.
  logic                  acc;
  logic                  s1_adv;
  logic                  s1_valid_r, s2_valid_r;
  bmrtc_pkg::target_t    s1_tgt_r, s1_tgt_nxt, s2_tgt_r;
  logic [20:0]           s1_rom_r, s1_rom_nxt, s2_rom_r;
  logic [7:0]            s1_byte_r, s1_byte_nxt, s2_byte_r;
  logic                  s1_err_r, s1_err_nxt, s2_err_r;
  logic                  s1_use_ram_r, s1_use_ram_nxt;

  logic [3:0] fitted;
  logic       sel_is_ram;
  logic       sel_is_clk;
  logic       val_is_clk;
  logic [15:0] addr;
  logic [7:0]  val;

  assign addr       = in_ch.bus_address;
  assign val        = in_ch.write_byte;
  assign fitted     = ({1'b0, bank_cnt_r} > BANKS_MAX) ? BANKS_MAX : {1'b0, bank_cnt_r};
  assign sel_is_ram = sel_r < fitted;
  assign sel_is_clk = (sel_r >= bmrtc_pkg::CLOCK_FIRST) && (sel_r <= bmrtc_pkg::CLOCK_LAST);
  assign val_is_clk = (val >= 8'(bmrtc_pkg::CLOCK_FIRST)) &&
                      (val <= 8'(bmrtc_pkg::CLOCK_LAST));
  assign item_addr  = ADDR_W'({sel_r, addr[12:0]});

  assign s1_adv      = s1_valid_r && (!s2_valid_r || out_ch.ready);
  assign in_ch.ready = !clearing_r && (!s1_valid_r || !s2_valid_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    ram_en_nxt     = ram_en_r;
    rom_bank_nxt   = rom_bank_r;
    sel_nxt        = sel_r;
    prev_nxt       = prev_r;
    latch_all      = 1'b0;
    latch_one      = 1'b0;
    item_ram_we    = 1'b0;
    s1_tgt_nxt     = bmrtc_pkg::TGT_NONE;
    s1_rom_nxt     = '0;
    s1_byte_nxt    = '0;
    s1_err_nxt     = 1'b0;
    s1_use_ram_nxt = 1'b0;
    priority if (!addr[15]) begin
      if (in_ch.opcode == bmrtc_pkg::OP_READ) begin
        s1_tgt_nxt = bmrtc_pkg::TGT_ROM;
        s1_rom_nxt = addr[14] ? {rom_bank_r, addr[13:0]} : {7'd0, addr[13:0]};
      end else begin
        s1_tgt_nxt = bmrtc_pkg::TGT_CONTROL;
        unique case (addr[14:13])
          bmrtc_pkg::CTL_RAM_ENABLE: begin
            ram_en_nxt = (val[3:0] == bmrtc_pkg::RAM_ENABLE_KEY);
          end
          bmrtc_pkg::CTL_ROM_BANK: begin
            rom_bank_nxt = (val[6:0] == 7'd0) ? bmrtc_pkg::ROM_BANK_RST : val[6:0];
          end
          bmrtc_pkg::CTL_SELECT: begin
            if ((val < 8'(fitted)) || val_is_clk) begin
              sel_nxt = val[3:0];
            end else begin
              s1_err_nxt = 1'b1;
            end
          end
          bmrtc_pkg::CTL_LATCH: begin
            latch_all = (prev_r == bmrtc_pkg::LATCH_ARM) && (val == bmrtc_pkg::LATCH_FIRE);
            prev_nxt  = val;
          end
          default: begin
            s1_err_nxt = 1'b1;
          end
        endcase
      end
    end else if (addr[15:13] == bmrtc_pkg::WINDOW_PAGE) begin
      s1_tgt_nxt = sel_is_ram ? bmrtc_pkg::TGT_RAM :
                   (sel_is_clk ? bmrtc_pkg::TGT_CLOCK : bmrtc_pkg::TGT_NONE);
      if (!ram_en_r || (!sel_is_ram && !sel_is_clk)) begin
        s1_err_nxt = 1'b1;
        if (in_ch.opcode == bmrtc_pkg::OP_READ) begin
          s1_byte_nxt = bmrtc_pkg::REFUSED_BYTE;
        end
      end else if (sel_is_ram) begin
        if (in_ch.opcode == bmrtc_pkg::OP_WRITE) begin
          item_ram_we = 1'b1;
        end else begin
          s1_use_ram_nxt = 1'b1;
        end
      end else begin
        if (in_ch.opcode == bmrtc_pkg::OP_WRITE) begin
          if (in_ch.live_clock[bmrtc_pkg::HALT_BIT]) begin
            latch_one = 1'b1;
          end else begin
            s1_err_nxt = 1'b1;
          end
        end else begin
          s1_byte_nxt = clk_lat_r[sel_r[2:0]];
        end
      end
    end else begin
      s1_err_nxt = 1'b1;
      if (in_ch.opcode == bmrtc_pkg::OP_READ) begin
        s1_byte_nxt = bmrtc_pkg::REFUSED_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_cnt_r <= bmrtc_pkg::CFG_BANKS_RST;
    end else if (cfg_we) begin
      bank_cnt_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_en_r   <= 1'b0;
      rom_bank_r <= bmrtc_pkg::ROM_BANK_RST;
      sel_r      <= '0;
      prev_r     <= '0;
      for (int i = 0; i < 5; i++) begin
        clk_lat_r[i] <= '0;
      end
    end else if (acc) begin
      ram_en_r   <= ram_en_nxt;
      rom_bank_r <= rom_bank_nxt;
      sel_r      <= sel_nxt;
      prev_r     <= prev_nxt;
      for (int i = 0; i < 5; i++) begin
        if (latch_all) begin
          clk_lat_r[i] <= in_ch.live_clock[8*i +: 8];
        end else if (latch_one && (sel_r[2:0] == 3'(i))) begin
          clk_lat_r[i] <= val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign ram_we    = clearing_r || (acc && item_ram_we);
  assign ram_waddr = clearing_r ? clr_addr_r : item_addr;
  assign ram_wdata = clearing_r ? 8'd0 : val;

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ram_q_r <= ram_mem[item_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_tgt_r     <= s1_tgt_nxt;
      s1_rom_r     <= s1_rom_nxt;
      s1_byte_r    <= s1_byte_nxt;
      s1_err_r     <= s1_err_nxt;
      s1_use_ram_r <= s1_use_ram_nxt;
    end
    if (s1_adv) begin
      s2_tgt_r  <= s1_tgt_r;
      s2_rom_r  <= s1_rom_r;
      s2_byte_r <= s1_use_ram_r ? ram_q_r : s1_byte_r;
      s2_err_r  <= s1_err_r;
    end
  end

  assign out_ch.valid        = s2_valid_r;
  assign out_ch.target       = s2_tgt_r;
  assign out_ch.rom_address  = s2_rom_r;
  assign out_ch.read_byte    = s2_byte_r;
  assign out_ch.access_error = s2_err_r;

  a_no_transfer_while_clearing : assert property (
    @(posedge clk) disable iff (!rst_n) clearing_r |-> !in_ch.ready
  ) else $error("Input ready raised during the RAM clearing sweep.");

  a_transfer_fills_read_stage : assert property (
    @(posedge clk) disable iff (!rst_n) acc |=> s1_valid_r
  ) else $error("Transferred access did not reach the read stage.");

  a_rom_bank_nonzero : assert property (
    @(posedge clk) disable iff (!rst_n) rom_bank_r != 7'd0
  ) else $error("Upper ROM bank register holds zero.");

  a_select_in_range : assert property (
    @(posedge clk) disable iff (!rst_n) sel_r <= bmrtc_pkg::CLOCK_LAST
  ) else $error("Select register holds a code beyond the clock registers.");

endmodule

>>> tb/tb_bank_mapper_with_rtc_latch_unit.sv
`timescale 1ns / 100ps

module tb_bank_mapper_with_rtc_latch_unit;

  typedef struct packed {
    bmrtc_pkg::target_t target;
    logic [20:0]        rom_address;
    logic [7:0]         read_byte;
    logic               access_error;
  } access_result_t;

  typedef struct {
    logic           op;
    logic [15:0]    addr;
    logic [7:0]     wbyte;
    logic [39:0]    live;
    bit             typed;
    access_result_t res;
  } bus_row_t;

  localparam access_result_t NO_RESULT = '{bmrtc_pkg::TGT_NONE, 21'h0, 8'h00, 1'b0};
  localparam logic [39:0] HALTED_CLOCK = 40'h40_0000_0000;
  localparam logic [39:0] ALL_ONES_CLOCK = 40'hFF_FFFF_FFFF;
  localparam int ITEMS_PER_PHASE = 65;
  localparam logic [2:0] PHASE_BANK_COUNT [0:7] = '{3'd2, 3'd0, 3'd7, 3'd1,
                                                    3'd4, 3'd3, 3'd5, 3'd6};

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  bmrtc_in_if  in_ch ();
  bmrtc_out_if out_ch ();

  bank_mapper_with_rtc_latch_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the mapper state.
  logic [2:0] bank_count;
  logic       ram_on;
  logic [6:0] rom_bank;
  logic [3:0] window_sel;
  logic [7:0] last_latch;
  logic [7:0] rtc_latch [0:4];
  logic [7:0] cart_ram [0:bmrtc_pkg::RAM_BANKS_DEF*bmrtc_pkg::BANK_BYTES-1];

  access_result_t pending_results[$];
  bus_row_t       access_table[$];

  int fail_count    = 0;
  int send_idle_pct = 29;
  int recv_idle_pct = 55;
  bit long_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic access_result_t mapper_access(logic op, logic [15:0] addr,
                                                   logic [7:0] wb, logic [39:0] live);
    access_result_t r;
    int             fitted;
    int             idx;
    logic           is_ram;
    logic           is_clk;
    r = NO_RESULT;
    fitted = (int'(bank_count) > bmrtc_pkg::RAM_BANKS_DEF) ? bmrtc_pkg::RAM_BANKS_DEF :
             int'(bank_count);
    if (!addr[15]) begin
      if (op == bmrtc_pkg::OP_READ) begin
        r.target = bmrtc_pkg::TGT_ROM;
        r.rom_address = addr[14] ? {rom_bank, addr[13:0]} : {5'd0, addr};
      end else begin
        r.target = bmrtc_pkg::TGT_CONTROL;
        case (addr[14:13])
          bmrtc_pkg::CTL_RAM_ENABLE: ram_on = (wb[3:0] == bmrtc_pkg::RAM_ENABLE_KEY);
          bmrtc_pkg::CTL_ROM_BANK: rom_bank = (wb[6:0] == 7'd0) ? 7'd1 : wb[6:0];
          bmrtc_pkg::CTL_SELECT: begin
            if (int'(wb) < fitted ||
                (wb >= bmrtc_pkg::CLOCK_FIRST && wb <= bmrtc_pkg::CLOCK_LAST)) begin
              window_sel = wb[3:0];
            end else begin
              r.access_error = 1'b1;
            end
          end
          bmrtc_pkg::CTL_LATCH: begin
            if (last_latch == bmrtc_pkg::LATCH_ARM && wb == bmrtc_pkg::LATCH_FIRE) begin
              for (int i = 0; i < 5; i++) rtc_latch[i] = live[8*i +: 8];
            end
            last_latch = wb;
          end
        endcase
      end
    end else if (addr[15:13] == bmrtc_pkg::WINDOW_PAGE) begin
      is_ram = int'(window_sel) < fitted;
      is_clk = window_sel >= bmrtc_pkg::CLOCK_FIRST && window_sel <= bmrtc_pkg::CLOCK_LAST;
      r.target = is_ram ? bmrtc_pkg::TGT_RAM :
                 (is_clk ? bmrtc_pkg::TGT_CLOCK : bmrtc_pkg::TGT_NONE);
      if (!ram_on || !(is_ram || is_clk)) begin
        r.access_error = 1'b1;
        if (op == bmrtc_pkg::OP_READ) r.read_byte = bmrtc_pkg::REFUSED_BYTE;
      end else if (is_ram) begin
        idx = int'(window_sel) * bmrtc_pkg::BANK_BYTES + int'(addr[12:0]);
        if (op == bmrtc_pkg::OP_WRITE) cart_ram[idx] = wb;
        else r.read_byte = cart_ram[idx];
      end else if (op == bmrtc_pkg::OP_WRITE) begin
        if (live[bmrtc_pkg::HALT_BIT]) rtc_latch[window_sel - bmrtc_pkg::CLOCK_FIRST] = wb;
        else r.access_error = 1'b1;
      end else begin
        r.read_byte = rtc_latch[window_sel - bmrtc_pkg::CLOCK_FIRST];
      end
    end else begin
      r.access_error = 1'b1;
      if (op == bmrtc_pkg::OP_READ) r.read_byte = bmrtc_pkg::REFUSED_BYTE;
    end
    return r;
  endfunction

  task automatic send_access(input bus_row_t row);
    access_result_t predicted;
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= row.op;
    in_ch.bus_address <= row.addr;
    in_ch.write_byte  <= row.wbyte;
    in_ch.live_clock  <= row.live;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = mapper_access(row.op, row.addr, row.wbyte, row.live);
    pending_results.push_back(row.typed ? row.res : predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no access outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.target !== want.target) begin
          $error("target: expected %0d, actual %0d", want.target, out_ch.target);
          fail_count++;
        end
        if (out_ch.rom_address !== want.rom_address) begin
          $error("rom_address: expected %h, actual %h", want.rom_address,
                 out_ch.rom_address);
          fail_count++;
        end
        if (out_ch.read_byte !== want.read_byte) begin
          $error("read_byte: expected %h, actual %h", want.read_byte, out_ch.read_byte);
          fail_count++;
        end
        if (out_ch.access_error !== want.access_error) begin
          $error("access_error: expected %0b, actual %0b", want.access_error,
                 out_ch.access_error);
          fail_count++;
        end
      end
    end
  end

  initial begin
    bus_row_t row;
    int       pick;
    int       sel;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= bmrtc_pkg::CFG_BANKS_RST;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= bmrtc_pkg::OP_READ;
    in_ch.bus_address <= 16'h0000;
    in_ch.write_byte  <= 8'h00;
    in_ch.live_clock  <= 40'h0;

    access_table.push_back('{bmrtc_pkg::OP_READ, 16'h0000, 8'h00, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_ROM, 21'h0, 8'h00, 1'b0}});
    access_table.push_back('{bmrtc_pkg::OP_READ, 16'h7FFF, 8'h00, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_ROM, 21'h007FFF, 8'h00, 1'b0}});
    access_table.push_back('{bmrtc_pkg::OP_READ, 16'hA000, 8'h00, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_RAM, 21'h0, bmrtc_pkg::REFUSED_BYTE, 1'b1}});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'hBFFF, 8'h55, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_RAM, 21'h0, 8'h00, 1'b1}});
    access_table.push_back('{bmrtc_pkg::OP_READ, 16'h8000, 8'h00, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_NONE, 21'h0, bmrtc_pkg::REFUSED_BYTE, 1'b1}});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'hFFFF, 8'hAA, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_NONE, 21'h0, 8'h00, 1'b1}});
    access_table.push_back('{bmrtc_pkg::OP_READ, 16'hC000, 8'h00, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_NONE, 21'h0, bmrtc_pkg::REFUSED_BYTE, 1'b1}});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'h3FFF, 8'hFF, 40'h0, 1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_READ, 16'h7FFF, 8'h00, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_ROM, 21'h1FFFFF, 8'h00, 1'b0}});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'h1FFF, 8'h1A, 40'h0, 1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'hBFFF, 8'h5A, 40'h0, 1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_READ, 16'hBFFF, 8'h00, 40'h0, 1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'h4000, 8'h04, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_CONTROL, 21'h0, 8'h00, 1'b1}});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'h5FFF, 8'h03, 40'h0, 1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'hA123, 8'hC3, ALL_ONES_CLOCK, 1'b0,
                             NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_READ, 16'hA123, 8'h00, 40'h0, 1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'h4000, 8'h0D, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_CONTROL, 21'h0, 8'h00, 1'b1}});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'h4000, 8'h0C, 40'h0, 1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'h6000, bmrtc_pkg::LATCH_ARM, 40'h0,
                             1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'h7FFF, bmrtc_pkg::LATCH_FIRE,
                             ALL_ONES_CLOCK, 1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_READ, 16'hA000, 8'h00, 40'h0, 1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'hA000, 8'h12, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_CLOCK, 21'h0, 8'h00, 1'b1}});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'hA000, 8'h34, HALTED_CLOCK, 1'b0,
                             NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_READ, 16'hA000, 8'h00, 40'h0, 1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_WRITE, 16'h0000, 8'h00, 40'h0, 1'b0, NO_RESULT});
    access_table.push_back('{bmrtc_pkg::OP_READ, 16'hA000, 8'h00, 40'h0, 1'b1,
                             '{bmrtc_pkg::TGT_CLOCK, 21'h0, bmrtc_pkg::REFUSED_BYTE, 1'b1}});

    bank_count = bmrtc_pkg::CFG_BANKS_RST;
    ram_on     = 1'b0;
    rom_bank   = bmrtc_pkg::ROM_BANK_RST;
    window_sel = 4'h0;
    last_latch = 8'h00;
    for (int i = 0; i < 5; i++) rtc_latch[i] = 8'h00;
    foreach (cart_ram[i]) cart_ram[i] = 8'h00;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (access_table[i]) send_access(access_table[i]);

    for (int p = 0; p < 8; p++) begin
      wait_all_results();
      cfg_we    <= 1'b1;
      cfg_wdata <= PHASE_BANK_COUNT[p];
      @(posedge clk);
      cfg_we     <= 1'b0;
      bank_count  = PHASE_BANK_COUNT[p];
      if (p < 3) begin
        send_idle_pct = 29;
        recv_idle_pct = 55;
      end else if (p < 6) begin
        send_idle_pct = 55;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // The output is held off for a long stretch while accesses keep coming,
      // so that the pipeline fills and the input stalls.
      if (p == 6) long_hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        row.typed = 1'b0;
        row.res   = NO_RESULT;
        row.op    = bmrtc_pkg::OP_WRITE;
        row.wbyte = 8'($urandom);
        row.live  = {8'($urandom), 32'($urandom)};
        pick = $urandom_range(99);
        if (pick < 8) begin
          row.addr = {1'b0, bmrtc_pkg::CTL_RAM_ENABLE, 13'($urandom)};
          if ($urandom_range(3) != 0) row.wbyte[3:0] = bmrtc_pkg::RAM_ENABLE_KEY;
        end else if (pick < 15) begin
          row.addr = {1'b0, bmrtc_pkg::CTL_ROM_BANK, 13'($urandom)};
          if ($urandom_range(4) == 0) row.wbyte[6:0] = 7'd0;
        end else if (pick < 27) begin
          row.addr = {1'b0, bmrtc_pkg::CTL_SELECT, 13'($urandom)};
          if ($urandom_range(9) < 7) begin
            sel = $urandom_range(8);
            row.wbyte = (sel < 4) ? 8'(sel) : 8'(bmrtc_pkg::CLOCK_FIRST) + 8'(sel - 4);
          end
        end else if (pick < 37) begin
          row.addr = {1'b0, bmrtc_pkg::CTL_LATCH, 13'($urandom)};
          sel = $urandom_range(4);
          if (sel < 2) row.wbyte = bmrtc_pkg::LATCH_ARM;
          else if (sel < 4) row.wbyte = bmrtc_pkg::LATCH_FIRE;
        end else if (pick < 52) begin
          row.op   = bmrtc_pkg::OP_READ;
          row.addr = {1'b0, 15'($urandom)};
        end else if (pick < 92) begin
          row.op   = 1'($urandom_range(1));
          row.addr = {bmrtc_pkg::WINDOW_PAGE,
                      ($urandom_range(9) < 7) ? 13'($urandom_range(15)) : 13'($urandom)};
        end else begin
          row.op   = 1'($urandom_range(1));
          row.addr = 16'($urandom);
        end
        send_access(row);
      end
    end

    wait_all_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
